### src/sequential_list_engine_unit_assert.svh
// Assertion macros for the sequential list engine.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sle_pkg.sv
// Shared types and codes of the sequential list engine.
`default_nettype none
package sle_pkg;

  localparam logic [2:0] MODE_APPEND  = 3'd0;
  localparam logic [2:0] MODE_INSERT  = 3'd1;
  localparam logic [2:0] MODE_DELETE  = 3'd2;
  localparam logic [2:0] MODE_REVERSE = 3'd3;
  localparam logic [2:0] MODE_SORT    = 3'd4;
  localparam logic [2:0] MODE_SHOW    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam int RUN_LIMIT = 16;

  typedef logic signed [31:0] sle_word_t;

  // per-cycle move control of one cell
  typedef struct packed {
    logic take_ins;
    logic take_left;
    logic take_right;
    logic take_head;
    logic pair_lo;
    logic pair_hi;
    logic sort_mode;
  } sle_cell_ctl_t;

endpackage
`default_nettype wire

### src/sequential_list_engine_unit.sv
// Top level of the sequential list engine: control sequencer over a row of list cells.
//
//  channel | ports                                           | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid in_ready in_mode in_position in_value  | in
//  out     | out_valid out_ready out_status out_element      | out
//          | out_element_index out_last                      |
//  cfg     | cfg_valid cfg_ready cfg_data                    | in
//
// An item passes through a decode state; append, insert and delete finish there.
// Reverse and sort run count odd-even transposition phases, one per cycle,
// then the list rotates once around the cells, one entry per cycle, to list it.
// A stalled result holds the rotation; reset empties the list and sets capacity 16.
`default_nettype none
module sequential_list_engine_unit #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         in_mode,
  input  wire  [3:0]         in_position,
  input  sle_pkg::sle_word_t in_value,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         out_status,
  output sle_pkg::sle_word_t out_element,
  output logic [3:0]         out_element_index,
  output logic               out_last,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [4:0]         cfg_data
);
  import sle_pkg::*;

  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CNTW > 5) ? CNTW : 5;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_NET  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] k_r, k_nxt;
  logic [CNTW-1:0] ph_r, ph_nxt;
  logic [4:0]      cap_r, cap_nxt;
  logic [2:0]      mode_r;
  logic [3:0]      pos_r;
  sle_word_t       val_r;

  logic            ov_r, ov_nxt;
  logic [1:0]      ost_r, ost_nxt;
  sle_word_t       oel_r, oel_nxt;
  logic [3:0]      oidx_r, oidx_nxt;
  logic            olast_r, olast_nxt;

  sle_word_t       cell_q [MAX_ENTRIES];
  sle_cell_ctl_t   ctl [MAX_ENTRIES];

  logic [CMPW-1:0] cntx, posx, capx, effcap, lim, ins_at;
  logic            slot_free, do_ins, do_del, net_step, emit_step;
  logic            st_full, st_badins, st_badpos;
  sle_word_t       del_el;

  assign cntx = CMPW'(cnt_r);
  assign posx = CMPW'(pos_r);
  assign capx = CMPW'(cap_r);
  assign effcap = (capx == '0) ? CMPW'(1) :
                  (capx > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES) : capx;
  assign lim = (cntx > CMPW'(RUN_LIMIT)) ? CMPW'(RUN_LIMIT) : cntx;
  assign slot_free = !ov_r || out_ready;

  assign st_full   = cntx >= effcap;
  assign st_badins = posx > cntx;
  assign st_badpos = posx >= cntx;
  assign ins_at    = (mode_r == MODE_APPEND) ? cntx : posx;

  assign do_ins = (state_r == S_DEC) && slot_free && !st_full &&
                  ((mode_r == MODE_APPEND) || ((mode_r == MODE_INSERT) && !st_badins));
  assign do_del = (state_r == S_DEC) && slot_free && (mode_r == MODE_DELETE) &&
                  (cnt_r != '0) && !st_badpos;
  assign net_step  = state_r == S_NET;
  assign emit_step = (state_r == S_EMIT) && (cnt_r != '0) &&
                     ((CMPW'(k_r) >= lim) || slot_free);

  always_comb begin
    del_el = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (CMPW'(i) == posx) begin
        del_el = del_el | cell_q[i];
      end
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    localparam logic [CMPW-1:0] IDX  = CMPW'(g);
    localparam logic [CMPW-1:0] IDX1 = CMPW'(g + 1);
    localparam logic            PAR  = 1'(g % 2);
    sle_word_t left_d, right_d;

    always_comb begin
      ctl[g].take_ins   = do_ins && (IDX == ins_at);
      ctl[g].take_left  = do_ins && (IDX > ins_at) && (IDX <= cntx);
      ctl[g].take_right = (do_del && (IDX >= posx) && (IDX1 < cntx)) ||
                          (emit_step && (IDX1 < cntx));
      ctl[g].take_head  = emit_step && (IDX1 == cntx);
      ctl[g].pair_lo    = net_step && (IDX1 < cntx) && (ph_r[0] == PAR);
      ctl[g].pair_hi    = net_step && (g >= 1) && (IDX < cntx) && (ph_r[0] != PAR);
      ctl[g].sort_mode  = mode_r == MODE_SORT;
    end

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_q[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[g+1];
    end

    sle_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .ins_data   (val_r),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .data       (cell_q[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    cap_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cap_r;
    ov_nxt    = ov_r && !out_ready;
    ost_nxt   = ost_r;
    oel_nxt   = oel_r;
    oidx_nxt  = oidx_r;
    olast_nxt = olast_r;
    in_ready  = state_r == S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (mode_r)
          MODE_APPEND, MODE_INSERT, MODE_DELETE: begin
            if (slot_free) begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              oel_nxt   = '0;
              oidx_nxt  = '0;
              state_nxt = S_IDLE;
              if (mode_r == MODE_DELETE) begin
                if (cnt_r == '0) begin
                  ost_nxt = ST_EMPTY;
                end else if (st_badpos) begin
                  ost_nxt = ST_BADPOS;
                end else begin
                  ost_nxt  = ST_OK;
                  oel_nxt  = del_el;
                  oidx_nxt = pos_r;
                  cnt_nxt  = cnt_r - 1'b1;
                end
              end else if (st_full) begin
                ost_nxt = ST_FULL;
              end else if ((mode_r == MODE_INSERT) && st_badins) begin
                ost_nxt = ST_BADPOS;
              end else begin
                ost_nxt  = ST_OK;
                oidx_nxt = 4'(ins_at);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
          end
          MODE_REVERSE, MODE_SORT: begin
            ph_nxt    = '0;
            k_nxt     = '0;
            state_nxt = (cnt_r == '0) ? S_EMIT : S_NET;
          end
          MODE_SHOW: begin
            k_nxt     = '0;
            state_nxt = S_EMIT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_NET: begin
        ph_nxt = ph_r + 1'b1;
        if (ph_r == cnt_r - 1'b1) begin
          ph_nxt    = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cnt_r == '0) begin
          if (slot_free) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_EMPTY;
            oel_nxt   = '0;
            oidx_nxt  = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (emit_step) begin
          if (CMPW'(k_r) < lim) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            oel_nxt   = cell_q[0];
            oidx_nxt  = 4'(k_r);
            olast_nxt = (CMPW'(k_r) + CMPW'(1)) == lim;
          end
          k_nxt = k_r + 1'b1;
          if (k_r == cnt_r - 1'b1) begin
            k_nxt     = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      ph_r    <= '0;
      cap_r   <= 5'd16;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      ph_r    <= ph_nxt;
      cap_r   <= cap_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
    ost_r   <= ost_nxt;
    oel_r   <= oel_nxt;
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_element       = oel_r;
  assign out_element_index = oidx_r;
  assign out_last          = olast_r;

`include "sequential_list_engine_unit_assert.svh"

  `SLE_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= MAX_ENTRIES, "entry count above store depth")
  `SLE_ASSERT_NXT(a_acc_dec, in_valid && in_ready, state_r == S_DEC, "item not decoded")
  `SLE_ASSERT_NXT(a_cnt_src, state_r != S_DEC, $stable(cnt_r), "count moved outside decode")
  `SLE_ASSERT_IMP(a_emit_k, state_r == S_EMIT && cnt_r != '0, k_r < cnt_r, "rotation overrun")

endmodule
`default_nettype wire

### src/sle_cell.sv
// One list cell: holds an entry and moves or compare-swaps with its neighbors.
`default_nettype none
module sle_cell (
  input  wire                    clk,
  input  sle_pkg::sle_cell_ctl_t ctl,
  input  sle_pkg::sle_word_t     ins_data,
  input  sle_pkg::sle_word_t     left_data,
  input  sle_pkg::sle_word_t     right_data,
  input  sle_pkg::sle_word_t     head_data,
  output sle_pkg::sle_word_t     data
);
  import sle_pkg::*;

  sle_word_t data_r;
  sle_word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    priority if (ctl.take_ins) begin
      data_nxt = ins_data;
    end else if (ctl.take_left) begin
      data_nxt = left_data;
    end else if (ctl.take_right) begin
      data_nxt = right_data;
    end else if (ctl.take_head) begin
      data_nxt = head_data;
    end else if (ctl.pair_lo && (!ctl.sort_mode || (right_data < data_r))) begin
      data_nxt = right_data;
    end else if (ctl.pair_hi && (!ctl.sort_mode || (data_r < left_data))) begin
      data_nxt = left_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

### tb/sequential_list_engine_unit_test.sv
// Testbench of the sequential list engine: directed and random list operations checked against a mirror list.
`default_nettype none
module sequential_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int LIST_DEPTH = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam sle_word_t WORD_MIN = 32'sh8000_0000;
  localparam sle_word_t WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0] status;
    sle_word_t  element;
    logic [3:0] elem_index;
    logic       last;
  } list_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_mode = MODE_SHOW;
  logic [3:0] in_position = '0;
  sle_word_t  in_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  sle_word_t  out_element;
  logic [3:0] out_element_index;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  sle_word_t    mirror_list [LIST_DEPTH];
  int           mirror_count = 0;
  logic [4:0]   mirror_cap = 5'd16;
  list_result_t results_due [$];

  int errors = 0;
  int ops_done = 0;
  int results_seen = 0;
  int cap_writes = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  sequential_list_engine_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_index (out_element_index),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int usable_capacity();
    int c;
    c = mirror_cap;
    if (c == 0) c = 1;
    if (c > LIST_DEPTH) c = LIST_DEPTH;
    return c;
  endfunction

  function automatic void push_result(input logic [1:0] st, input sle_word_t el, input int idx,
                                      input logic lst);
    list_result_t r;
    r.status = st;
    r.element = el;
    r.elem_index = idx[3:0];
    r.last = lst;
    results_due.push_back(r);
  endfunction

  function automatic void list_run();
    int i;
    if (mirror_count == 0) begin
      push_result(ST_EMPTY, '0, 0, 1'b1);
    end else begin
      for (i = 0; i < mirror_count; i++)
        push_result(ST_OK, mirror_list[i], i, i == mirror_count - 1);
    end
  endfunction

  function automatic void apply_list_op(input logic [2:0] mode, input logic [3:0] pos_in,
                                        input sle_word_t val);
    int i;
    int j;
    int pos;
    sle_word_t t;
    pos = pos_in;
    case (mode)
      MODE_APPEND: begin
        if (mirror_count >= usable_capacity()) begin
          push_result(ST_FULL, '0, 0, 1'b1);
        end else begin
          mirror_list[mirror_count] = val;
          push_result(ST_OK, '0, mirror_count, 1'b1);
          mirror_count++;
        end
      end
      MODE_INSERT: begin
        if (mirror_count >= usable_capacity()) begin
          push_result(ST_FULL, '0, 0, 1'b1);
        end else if (pos > mirror_count) begin
          push_result(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (i = mirror_count; i > pos; i--) mirror_list[i] = mirror_list[i - 1];
          mirror_list[pos] = val;
          mirror_count++;
          push_result(ST_OK, '0, pos, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (mirror_count == 0) begin
          push_result(ST_EMPTY, '0, 0, 1'b1);
        end else if (pos >= mirror_count) begin
          push_result(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          t = mirror_list[pos];
          for (i = pos; i + 1 < mirror_count; i++) mirror_list[i] = mirror_list[i + 1];
          mirror_count--;
          push_result(ST_OK, t, pos, 1'b1);
        end
      end
      MODE_REVERSE: begin
        i = 0;
        j = mirror_count - 1;
        while (i < j) begin
          t = mirror_list[i];
          mirror_list[i] = mirror_list[j];
          mirror_list[j] = t;
          i++;
          j--;
        end
        list_run();
      end
      MODE_SORT: begin
        for (i = 0; i < mirror_count; i++) begin
          for (j = i + 1; j < mirror_count; j++) begin
            if (mirror_list[j] < mirror_list[i]) begin
              t = mirror_list[i];
              mirror_list[i] = mirror_list[j];
              mirror_list[j] = t;
            end
          end
        end
        list_run();
      end
      MODE_SHOW: list_run();
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // mirror update on accepted items and register writes, result check on accepted results
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      mirror_count = 0;
      mirror_cap = 5'd16;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mirror_cap = cfg_data;
        cap_writes++;
      end
      if (in_valid && in_ready) begin
        if (in_mode != MODE_SPARE_LO && in_mode != MODE_SPARE_HI) ops_done++;
        apply_list_op(in_mode, in_position, in_value);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual status %h element %h index %h last %b",
                   $time, out_status, out_element, out_element_index, out_last);
        end else begin
          want = results_due.pop_front();
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("element", want.element, out_element);
          compare_field("element_index", 32'(want.elem_index), 32'(out_element_index));
          compare_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] mode, input logic [3:0] pos, input sle_word_t val);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_list();
    send_item(MODE_SHOW, 4'd0, '0);
    send_item(MODE_REVERSE, 4'd0, '0);
    send_item(MODE_SORT, 4'd0, '0);
    send_item(MODE_DELETE, 4'd15, '0);
  endtask

  task automatic test_full_list();
    write_capacity(5'd4);
    send_item(MODE_APPEND, 4'd0, WORD_MIN);
    send_item(MODE_APPEND, 4'd0, WORD_MAX);
    send_item(MODE_APPEND, 4'd0, 32'sd0);
    send_item(MODE_APPEND, 4'd0, -32'sd1);
    send_item(MODE_APPEND, 4'd0, 32'sd1);
    // full wins over a bad position
    send_item(MODE_INSERT, 4'd9, 32'sd5);
  endtask

  task automatic test_listing();
    send_item(MODE_SHOW, 4'd0, '0);
    send_item(MODE_REVERSE, 4'd0, '0);
    send_item(MODE_SORT, 4'd0, '0);
  endtask

  task automatic test_delete();
    send_item(MODE_DELETE, 4'd4, '0);
    send_item(MODE_DELETE, 4'd3, '0);
    send_item(MODE_DELETE, 4'd0, '0);
  endtask

  task automatic test_insert();
    send_item(MODE_INSERT, 4'd3, 32'sd77);
    send_item(MODE_INSERT, 4'd2, 32'sh5555_aaaa);
    send_item(MODE_INSERT, 4'd0, -32'sd12345);
  endtask

  task automatic test_capacity_edges();
    write_capacity(5'd0);
    send_item(MODE_APPEND, 4'd0, 32'sd3);
    write_capacity(5'd2);
    send_item(MODE_SHOW, 4'd0, '0);
    send_item(MODE_APPEND, 4'd0, 32'sd4);
    send_item(MODE_SPARE_LO, 4'd15, WORD_MAX);
    send_item(MODE_SPARE_HI, 4'd15, WORD_MIN);
    write_capacity(5'd31);
    send_item(MODE_APPEND, 4'd0, 32'sh0f0f_0f0f);
    send_item(MODE_SHOW, 4'd0, '0);
  endtask

  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles <= HOLD_OFF_CYCLES;
    for (k = 0; k < 24; k++) begin
      if (k % 2 == 0) send_item(MODE_SHOW, 4'd0, '0);
      else send_item(MODE_APPEND, 4'($urandom_range(15)), sle_word_t'($urandom));
    end
    drain_results();
  endtask

  task automatic send_random_item(input bit grow);
    int r;
    int fill;
    logic [2:0] mode;
    logic [3:0] pos;
    sle_word_t val;
    r = $urandom_range(99);
    fill = mirror_count;
    if (r < 3) mode = ($urandom_range(1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
    else if (r < (grow ? 35 : 15)) mode = MODE_APPEND;
    else if (r < (grow ? 60 : 28)) mode = MODE_INSERT;
    else if (r < 80) mode = MODE_DELETE;
    else if (r < 87) mode = MODE_REVERSE;
    else if (r < 93) mode = MODE_SORT;
    else mode = MODE_SHOW;
    if ($urandom_range(3) != 0) begin
      if (mode == MODE_DELETE && fill > 0) fill--;
      if (fill > 15) fill = 15;
      pos = 4'($urandom_range(fill));
    end else begin
      pos = 4'($urandom_range(15));
    end
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0: val = WORD_MIN;
        1: val = WORD_MAX;
        2: val = 32'sd0;
        default: val = -32'sd1;
      endcase
    end else begin
      val = sle_word_t'($urandom);
    end
    send_item(mode, pos, val);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [4:0] cap_a, input logic [4:0] cap_b,
                                   input int count);
    int k;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    write_capacity(cap_a);
    for (k = 0; k < count / 2; k++) send_random_item(k < count / 4);
    write_capacity(cap_b);
    for (k = 0; k < count / 2; k++) send_random_item(k < count / 4);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_full_list();
    test_listing();
    test_delete();
    test_insert();
    test_capacity_edges();
    test_backpressure();
    test_random_phase(30, 76, 5'd16, 5'($urandom_range(2, 15)), 60);
    test_random_phase(76, 30, 5'd1, 5'd31, 60);
    test_random_phase(0, 0, 5'($urandom_range(17, 30)), 5'd16, 60);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d list operations and %0d results over %0d capacity writes,",
             ops_done, results_seen, cap_writes);
    $display("with empty, full, bad-position, spare-mode and long receiver hold-off cases.");
    if (errors == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
